// ===== rtl/lzd4k_pkg.sv =====
// ============================================================================
// LZSS decoder package
// Shared constants, state encodings and the command and status structures
// that pass between the decoder's controller and datapath.
// ============================================================================
package lzd4k_pkg;

    localparam int RING_SIZE     = 4096;
    localparam int RING_AW       = $clog2(RING_SIZE);
    localparam int FILL_W        = RING_AW + 1;
    localparam int MAX_MATCH     = 18;
    localparam int MIN_MATCH_DEF = 3;
    localparam int WP_START      = RING_SIZE - MAX_MATCH;
    localparam int CNT_W         = $clog2(MAX_MATCH);
    localparam int FLAG_W        = 9;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_match;
        logic out_free;
        logic cnt_zero;
    } t_stat;

endpackage

// ===== rtl/lzss_decoder_4k.sv =====
// ============================================================================
// LZSS decoder, 4 KiB history
// Expands an LZSS byte stream one compressed byte per input transfer.
// ============================================================================
// A flag byte or the first byte of a match is taken and yields nothing. A
// literal is taken and yields one output transfer; it is held off only
// while the output register is full and stalled. After the second byte of
// a match (lengths 3 to 18) is taken, the input is stalled while the copy
// steps through a read state and a write state for each copied byte, the
// write waiting while the output side stalls: each copied byte needs one
// read of the history RAM, whose read data is registered, followed by the
// write of that byte back into the ring, so that an overlapping copy sees
// the byte it has just written. The run_last output marks the final byte
// produced by one input transfer. A stream start, given with the first flag
// byte of a new stream, empties the history without a clearing pass: the
// ring is always written in order from its start pointer, so a fill count
// tells which entries belong to the current stream, and every other entry
// reads as zero. The block is therefore ready straight after reset.
// ============================================================================
module lzss_decoder_4k
    import lzd4k_pkg::*;
#(
    parameter int MIN_MATCH = MIN_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    t_cmd  cmd;
    t_stat stat;

    // The controller decides when a transfer is taken and steps each match
    // copy through its read and write cycles.
    lzd4k_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath parses tokens, owns the ring and drives the output.
    lzd4k_dp #(
        .MIN_MATCH (MIN_MATCH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last)
    );

endmodule

// ===== rtl/lzd4k_ram.sv =====
// ============================================================================
// Generic single-clock RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module lzd4k_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lzd4k_ctrl.sv =====
// ============================================================================
// LZSS decoder controller
// Sequences input transfers and the read and write steps of a match copy.
// ============================================================================
module lzd4k_ctrl
    import lzd4k_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = !((r_state == ST_IDLE) && i_stat.out_free);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.is_match) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.cnt_zero ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lzd4k_dp.sv =====
// ============================================================================
// LZSS decoder datapath
// Token parser, history ring with its pointers, match counters and the
// output register.
// ============================================================================
module lzd4k_dp
    import lzd4k_pkg::*;
#(
    parameter int MIN_MATCH = MIN_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    t_phase              r_phase,     n_phase;
    logic [FLAG_W-1:0]   r_flags,     n_flags;
    logic [7:0]          r_low,       n_low;
    logic [RING_AW-1:0]  r_wp,        n_wp;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic [RING_AW-1:0]  r_pos,       n_pos;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic                r_hit,       n_hit;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte,  n_out_byte;
    logic                r_run_last,  n_run_last;

    t_phase              ph_eff;
    t_phase              end_phase;
    logic [FLAG_W-1:0]   flags_eff;
    logic [FLAG_W-1:0]   flags_shr;
    logic [RING_AW-1:0]  offset;
    logic                hit;
    logic                is_lit;
    logic                lit_emit;
    logic                wr_en;
    logic [7:0]          wr_data;
    logic [7:0]          rdata;
    logic                out_free;

    // A stream start restarts the parser before the byte is looked at.
    assign ph_eff    = i_stream_start ? PH_FLAG : r_phase;
    assign flags_eff = i_stream_start ? '0 : r_flags;
    assign flags_shr = {1'b0, flags_eff[FLAG_W-1:1]};
    assign end_phase = (flags_shr <= FLAG_W'(1)) ? PH_FLAG : PH_TOKEN;
    assign is_lit    = (ph_eff == PH_TOKEN) && flags_eff[0];

    // The ring is written strictly in order from the start pointer, so an
    // entry has been written since the last start exactly when its distance
    // from the start pointer is below the fill count.
    assign offset = r_pos - RING_AW'(WP_START);
    assign hit    = ({1'b0, offset} < r_fill);

    assign out_free = !r_out_valid || !i_out_stall;
    assign lit_emit = i_cmd.accept && is_lit;
    assign wr_en    = lit_emit || i_cmd.emit;
    assign wr_data  = i_cmd.emit ? (r_hit ? rdata : 8'h00) : i_in_byte;

    assign o_stat.is_match = (ph_eff == PH_HIGH);
    assign o_stat.out_free = out_free;
    assign o_stat.cnt_zero = (r_cnt == '0);

    lzd4k_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wp),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd),
        .i_raddr (r_pos),
        .o_rdata (rdata)
    );

    always_comb begin
        n_phase     = r_phase;
        n_flags     = r_flags;
        n_low       = r_low;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;

        if (i_cmd.accept) begin
            n_phase = ph_eff;
            n_flags = flags_eff;
            if (i_stream_start) begin
                n_low  = '0;
                n_wp   = RING_AW'(WP_START);
                n_fill = '0;
            end
            case (ph_eff)
                PH_TOKEN: begin
                    if (flags_eff[0]) begin
                        n_flags = flags_shr;
                        n_phase = end_phase;
                    end else begin
                        n_low   = i_in_byte;
                        n_phase = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    n_pos   = {i_in_byte[7:4], r_low};
                    n_cnt   = CNT_W'({1'b0, i_in_byte[3:0]} + MIN_MATCH - 1);
                    n_flags = flags_shr;
                    n_phase = end_phase;
                end
                default: begin
                    n_flags = {1'b1, i_in_byte};
                    n_phase = PH_TOKEN;
                end
            endcase
        end

        if (i_cmd.rd) begin
            n_hit = hit;
        end

        if (i_cmd.emit) begin
            n_pos = r_pos + 1'b1;
            n_cnt = r_cnt - 1'b1;
        end

        if (wr_en) begin
            n_wp = r_wp + 1'b1;
            if (r_fill != FILL_W'(RING_SIZE)) begin
                n_fill = r_fill + 1'b1;
            end
            n_out_valid = 1'b1;
            n_out_byte  = wr_data;
            n_run_last  = lit_emit || (r_cnt == '0);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_flags     <= '0;
            r_low       <= '0;
            r_wp        <= RING_AW'(WP_START);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_flags     <= n_flags;
            r_low       <= n_low;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_hit      <= n_hit;
        r_out_byte <= n_out_byte;
        r_run_last <= n_run_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;

endmodule

// ===== rtl/lzd4k_chk.sv =====
// ============================================================================
// LZSS decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ============================================================================
module lzd4k_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    // Reset leaves no output transfer pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled output holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output changed");

    // No input is taken while a result waits on a stalled output.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    // While a byte that is not the last of its run waits at the output, the
    // rest of the copy is still to come, so the input stays stalled.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> o_in_stall)
        else $error("input taken in the middle of a match");

endmodule

bind lzss_decoder_4k lzd4k_chk u_chk (.*);

// ===== tb/tb_lzss_decoder_4k.sv =====
`timescale 1ns / 100ps
// ============================================================================
// LZSS decoder testbench
// Feeds compressed byte streams into lzss_decoder_4k and checks every
// decompressed byte and its run_last marker against an in-bench decoder.
// ============================================================================
// The stimulus is built up front in a queue of compressed bytes. A short
// directed stream comes first, followed by randomly generated streams whose
// match positions mostly point just behind the current write position, so
// that copies read real history and often overlap the bytes they write.
// Now and then a stream is restarted part way through a flag group, which
// sometimes cuts a match in half.
//
// The driver takes bytes from that queue. At every input transfer it runs
// the byte through the in-bench decoder, which appends the expected output
// bytes to a queue. The monitor compares each output transfer with the oldest
// entry of that queue. Idling on both sides changes over the run in three
// stretches, and a few bytes are held back until all expected output has
// drained. A watchdog ends the run if no transfer takes place for too long.
// ============================================================================
module tb_lzss_decoder_4k;
    import lzd4k_pkg::*;

    // Rough number of compressed bytes sent over the whole run.
    localparam int ITEM_TARGET  = 230;
    // Longest copy with a busy receiver stays far below this quiet period.
    localparam int QUIET_LIMIT  = 4000;
    // A full-length match needs a read and a write step per byte; allow for that and more.
    localparam int TAIL_CYCLES  = 60;
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       hold;
    } comp_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_stream_start = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall    = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    // Compressed bytes still to be sent, and decoded bytes still to arrive.
    comp_item_t comp_stream[$];
    out_beat_t  expected_bytes[$];

    int total_items  = 0;
    int sent_count   = 0;
    int quiet_cycles = 0;
    int errors       = 0;

    // Write position of the stream generator, kept in step with the decoder.
    logic [11:0] gen_wp;

    // In-bench decoder state.
    logic [7:0]  ring_copy [RING_SIZE];
    logic [11:0] ring_wp;
    logic [8:0]  flag_bits;
    t_phase      parse_state;
    logic [7:0]  pend_low;

    lzss_decoder_4k i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // In-bench decoder
    // ------------------------------------------------------------------------

    // Every decoded byte goes into the ring at the write position and onto the
    // queue of expected output.
    task automatic put_byte(input logic [7:0] b, input logic last);
        out_beat_t beat;
        ring_copy[ring_wp] = b;
        ring_wp            = ring_wp + 12'd1;
        beat.data          = b;
        beat.last          = last;
        expected_bytes.push_back(beat);
    endtask

    // Drops the flag just used; once only the marker bit is left, the next
    // byte is a fresh flag byte.
    task automatic next_token();
        flag_bits   = flag_bits >> 1;
        parse_state = (flag_bits <= 9'd1) ? PH_FLAG : PH_TOKEN;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [11:0] src;
        int          len;
        if (start) begin
            for (int k = 0; k < RING_SIZE; k++) begin
                ring_copy[k] = 8'h00;
            end
            ring_wp     = 12'(WP_START);
            flag_bits   = '0;
            parse_state = PH_FLAG;
            pend_low    = 8'h00;
        end
        case (parse_state)
            PH_TOKEN: begin
                if (flag_bits[0]) begin
                    put_byte(b, 1'b1);
                    next_token();
                end else begin
                    pend_low    = b;
                    parse_state = PH_HIGH;
                end
            end
            PH_HIGH: begin
                src = {b[7:4], pend_low};
                len = int'(b[3:0]) + MIN_MATCH_DEF;
                // Byte by byte, so an overlapping copy picks up what it has
                // just written.
                for (int i = 0; i < len; i++) begin
                    put_byte(ring_copy[src + 12'(i)], i == len - 1);
                end
                next_token();
            end
            default: begin
                flag_bits   = {1'b1, b};
                parse_state = PH_TOKEN;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stream generation
    // ------------------------------------------------------------------------

    task automatic add_raw(input logic [7:0] b, input logic start, input logic hold);
        comp_item_t item;
        item.data  = b;
        item.start = start;
        item.hold  = hold;
        comp_stream.push_back(item);
    endtask

    task automatic add_flag(input logic [7:0] b, input logic start, input logic hold);
        if (start) begin
            gen_wp = 12'(WP_START);
        end
        add_raw(b, start, hold);
    endtask

    task automatic add_literal(input logic [7:0] b);
        add_raw(b, 1'b0, 1'b0);
        gen_wp = gen_wp + 12'd1;
    endtask

    task automatic add_match(input logic [11:0] pos, input logic [3:0] code);
        add_raw(pos[7:0], 1'b0, 1'b0);
        add_raw({pos[11:8], code}, 1'b0, 1'b0);
        gen_wp = gen_wp + 12'(code) + 12'(MIN_MATCH_DEF);
    endtask

    // ------------------------------------------------------------------------
    // Idling levels: the sender idles less than the receiver at first, then
    // the other way round, and in the last stretch neither idles.
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        if (sent_count < total_items / 3) begin
            return 31;
        end else if (sent_count < (2 * total_items) / 3) begin
            return 68;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_count < total_items / 3) begin
            return 68;
        end else if (sent_count < (2 * total_items) / 3) begin
            return 31;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    // At a transfer the byte is decoded straight away. A new byte is offered
    // only when the line is free, so an offered byte is never changed while
    // stalled. A byte marked hold waits until all expected output has come.
    always @(posedge i_clk) begin : drive
        logic       took;
        logic       offer;
        comp_item_t nxt;
        took = i_in_valid && !o_in_stall;
        if (took) begin
            decode_byte(i_in_byte, i_stream_start);
            sent_count++;
        end
        if (i_rst_n && (took || !i_in_valid)) begin
            offer = 1'b0;
            if (comp_stream.size() != 0) begin
                nxt   = comp_stream[0];
                offer = $urandom_range(0, 99) >= sender_idle_pct();
                if (nxt.hold && expected_bytes.size() != 0) begin
                    offer = 1'b0;
                end
            end
            if (offer) begin
                void'(comp_stream.pop_front());
                i_in_valid     <= 1'b1;
                i_in_byte      <= nxt.data;
                i_stream_start <= nxt.start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        out_beat_t want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                if (errors < PRINT_LIMIT) begin
                    $display("%0t: unexpected output, expected none, actual byte %02h last %b",
                             $time, o_out_byte, o_run_last);
                end
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (want.data !== o_out_byte || want.last !== o_run_last) begin
                    if (errors < PRINT_LIMIT) begin
                        $display("%0t: output mismatch, expected byte %02h last %b, actual byte %02h last %b",
                                 $time, want.data, want.last, o_out_byte, o_run_last);
                    end
                    errors++;
                end
            end
        end
        if (i_rst_n) begin
            i_out_stall <= $urandom_range(0, 99) < receiver_idle_pct();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Cycles since the last transfer on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : run
        logic [7:0]  fl;
        logic [11:0] pos;
        logic        force_start;
        logic        cut;
        logic        timed_out;

        // Directed stream. The flag byte alternates literal and match.
        add_flag(8'h55, 1'b1, 1'b0);
        add_literal(8'h00);
        // Full-length copy starting at the byte just written, so it repeats
        // itself and wraps the write position past the top of the ring.
        add_match(gen_wp - 12'd1, 4'hF);
        add_literal(8'hFF);
        // Shortest copy from position zero, overlapping its own output.
        add_match(12'h000, 4'h0);
        add_literal(8'h80);
        // Copy that reads across the top of the ring.
        add_match(12'hFFF, 4'h0);
        add_literal(8'h7F);
        // Copy from entries that have never been written in this stream.
        add_match(12'h800, 4'h7);
        // All-match flag byte, sent only once everything has drained, then a
        // match cut off after its first byte by a new stream.
        add_flag(8'h00, 1'b0, 1'b1);
        add_raw(8'h12, 1'b0, 1'b0);
        add_flag(8'hFF, 1'b1, 1'b0);
        add_literal(8'hA5);
        add_literal(8'h5A);
        // New stream in the middle of a flag group; the copy must read the
        // cleared history, not the literals of the stream before.
        add_flag(8'hFE, 1'b1, 1'b0);
        add_match(12'(WP_START), 4'h1);
        add_literal(8'h3C);

        // Random streams fill the run up to the target length.
        force_start = 1'b1;
        while (comp_stream.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                force_start = 1'b1;
            end
            fl = 8'($urandom_range(0, 255));
            add_flag(fl, force_start, $urandom_range(0, 14) == 0);
            force_start = 1'b0;
            cut         = 1'b0;
            for (int k = 0; k < 8 && !cut; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    // Abandon the stream here; for a match, after its first byte.
                    if (!fl[k]) begin
                        add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    end
                    force_start = 1'b1;
                    cut         = 1'b1;
                end else if (fl[k]) begin
                    add_literal(8'($urandom_range(0, 255)));
                end else begin
                    if ($urandom_range(0, 9) < 7) begin
                        pos = gen_wp - 12'($urandom_range(1, 40));
                    end else begin
                        pos = 12'($urandom_range(0, RING_SIZE - 1));
                    end
                    add_match(pos, 4'($urandom_range(0, 15)));
                end
            end
        end
        total_items = comp_stream.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!timed_out && !(sent_count == total_items && expected_bytes.size() == 0)) begin
            @(posedge i_clk);
            if (quiet_cycles >= QUIET_LIMIT) begin
                timed_out = 1'b1;
            end
        end
        if (!timed_out) begin
            // Anything the block still puts out now is caught by the monitor.
            repeat (TAIL_CYCLES) @(posedge i_clk);
        end else begin
            $display("%0t: watchdog expired, expected a transfer, actual none for %0d cycles",
                     $time, quiet_cycles);
            errors++;
        end
        if (expected_bytes.size() != 0) begin
            $display("%0t: missing output, expected %0d more bytes, actual none",
                     $time, expected_bytes.size());
            errors++;
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
